[rtl/quoted_string_tokenizer_core_assert.svh]
// assertion macros used by the checker file
`ifndef QUOTED_STRING_TOKENIZER_CORE_ASSERT_SVH
`define QUOTED_STRING_TOKENIZER_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define QST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// next-cycle implication, held off during reset
`define QST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

[rtl/qst_pkg.sv]
// ----------------------------------------------------------------------------
// qst_pkg
// shared types and constants for the quoted string tokenizer
// ----------------------------------------------------------------------------
package qst_pkg;

   localparam int LENGTH_WIDTH_DEFAULT = 16;
   localparam int OUT_LEN_W            = 16;
   localparam int MAX_RES              = 3;

   localparam logic [1:0] KIND_CHAR  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_PUNCT = 2'd2;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_SLASH  = 8'h2F;

   typedef struct packed {
      logic [1:0]           kind;
      logic [7:0]           char_out;
      logic [OUT_LEN_W-1:0] token_length;
      logic                 quoted;
   } result_type;

   typedef struct packed {
      result_type [MAX_RES-1:0] slot;
      logic [1:0]               count;
   } decode_res_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_LF) || (b == CH_CR) ||
             (b == CH_TAB) || (b == CH_NUL);
   endfunction

   function automatic logic is_punct(input logic [7:0] b);
      return (b == CH_SEMI) || (b == CH_COLON) || (b == CH_STAR) ||
             (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LBRACK) ||
             (b == CH_RBRACK) || (b == CH_LPAREN) || (b == CH_RPAREN) ||
             (b == CH_COMMA) || (b == CH_DOT) || (b == CH_EQUAL) ||
             (b == CH_AT) || (b == CH_SLASH);
   endfunction

endpackage

[rtl/qst_decode.sv]
// ----------------------------------------------------------------------------
// qst_decode
// classifies one byte, builds its results and the next tokenizer state
// ----------------------------------------------------------------------------
module qst_decode #(
   parameter int LENGTH_WIDTH = qst_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic [7:0]              in_byte,
   input  logic                    end_of_input,
   input  logic                    in_string,
   input  logic [LENGTH_WIDTH-1:0] pending,
   output qst_pkg::decode_res_type res,
   output logic                    in_string_next,
   output logic [LENGTH_WIDTH-1:0] pending_next
);
   import qst_pkg::*;

   logic                    str_mid;
   logic [LENGTH_WIDTH-1:0] pend_mid;
   logic [1:0]              n;
   result_type              end_pend;
   result_type              end_mid;
   result_type              char_res;
   result_type              punct_res;

   // saturate the reported length to the output width
   function automatic logic [OUT_LEN_W-1:0] sat_len(input logic [LENGTH_WIDTH-1:0] p);
      logic [31:0] p32;
      p32 = 32'(p);
      return (p32 > 32'(2**OUT_LEN_W - 1)) ? {OUT_LEN_W{1'b1}} : p32[OUT_LEN_W-1:0];
   endfunction

   always_comb begin
      end_pend.kind         = KIND_END;
      end_pend.char_out     = 8'd0;
      end_pend.token_length = sat_len(pending);
      end_pend.quoted       = in_string;

      char_res.kind         = KIND_CHAR;
      char_res.char_out     = in_byte;
      char_res.token_length = '0;
      char_res.quoted       = in_string;

      punct_res.kind         = KIND_PUNCT;
      punct_res.char_out     = in_byte;
      punct_res.token_length = '0;
      punct_res.quoted       = 1'b0;

      res.slot = '0;
      n        = 2'd0;
      str_mid  = in_string;
      pend_mid = '0;

      priority if (in_byte == CH_QUOTE) begin
         if (in_string || (pending != '0)) begin
            res.slot[n] = end_pend;
            n           = n + 2'd1;
         end
         str_mid = !in_string;
      end else if (!in_string && is_space(in_byte)) begin
         if (pending != '0) begin
            res.slot[n] = end_pend;
            n           = n + 2'd1;
         end
      end else if (!in_string && is_punct(in_byte)) begin
         if (pending != '0) begin
            res.slot[n] = end_pend;
            n           = n + 2'd1;
         end
         res.slot[n] = punct_res;
         n           = n + 2'd1;
      end else begin
         res.slot[n] = char_res;
         n           = n + 2'd1;
         pend_mid    = (pending == '1) ? pending : pending + 1'b1;
      end

      end_mid.kind         = KIND_END;
      end_mid.char_out     = 8'd0;
      end_mid.token_length = sat_len(pend_mid);
      end_mid.quoted       = str_mid;

      in_string_next = str_mid;
      pending_next   = pend_mid;
      // end of input flushes the open token and returns to the idle state
      if (end_of_input) begin
         if (str_mid || (pend_mid != '0)) begin
            res.slot[n] = end_mid;
            n           = n + 2'd1;
         end
         in_string_next = 1'b0;
         pending_next   = '0;
      end
      res.count = n;
   end

endmodule

[rtl/qst_out_buf.sv]
// ----------------------------------------------------------------------------
// qst_out_buf
// result register holding the words of one byte, handed out one per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module qst_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  qst_pkg::decode_res_type load_res,
   output logic                    can_load,
   output logic                    out_valid,
   input  logic                    out_ready,
   output qst_pkg::result_type     out_res,
   output logic                    out_last
);
   import qst_pkg::*;

   result_type [MAX_RES-1:0] slot_ff;
   logic [1:0]               rem_ff, rem_in;
   logic [1:0]               idx_ff, idx_in;
   logic                     take;

   assign out_valid = (rem_ff != 2'd0);
   assign out_last  = (rem_ff == 2'd1);
   assign out_res   = slot_ff[idx_ff];
   assign take      = out_valid && out_ready;
   // free once empty or once the final word leaves this cycle
   assign can_load  = (rem_ff == 2'd0) || (out_last && out_ready);

   always_comb begin
      rem_in = rem_ff;
      idx_in = idx_ff;
      if (load) begin
         rem_in = load_res.count;
         idx_in = 2'd0;
      end else if (take) begin
         rem_in = rem_ff - 2'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
         idx_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= load_res.slot;
      end
   end

endmodule

[rtl/quoted_string_tokenizer_core.sv]
// output: first result of a byte is offered from the result register in the cycle after the byte is accepted
// throughput: one byte per cycle when each byte gives at most one result and the receiver is ready;
//   a byte giving several results holds the input until its last result is taken at the single result port
// reset: synchronous, clears string mode and the pending length and empties the result register
// ----------------------------------------------------------------------------
// quoted_string_tokenizer_core
// splits a byte stream into tokens, punctuation and quoted strings
// ----------------------------------------------------------------------------
module quoted_string_tokenizer_core #(
   parameter int LENGTH_WIDTH = qst_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_in_byte,
   input  logic                          req_end_of_input,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_kind,
   output logic [7:0]                    rsp_char_out,
   output logic [qst_pkg::OUT_LEN_W-1:0] rsp_token_length,
   output logic                          rsp_quoted,
   output logic                          rsp_last
);
   import qst_pkg::*;

   logic                    in_string_ff, in_string_in;
   logic [LENGTH_WIDTH-1:0] pending_ff, pending_in;
   decode_res_type          dec_res;
   result_type              out_res;
   logic                    accept;

   assign accept = req_valid && req_ready;

   qst_decode #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) u_decode (
      .in_byte        (req_in_byte),
      .end_of_input   (req_end_of_input),
      .in_string      (in_string_ff),
      .pending        (pending_ff),
      .res            (dec_res),
      .in_string_next (in_string_in),
      .pending_next   (pending_in)
   );

   qst_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_res  (dec_res),
      .can_load  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_res   (out_res),
      .out_last  (rsp_last)
   );

   assign rsp_kind         = out_res.kind;
   assign rsp_char_out     = out_res.char_out;
   assign rsp_token_length = out_res.token_length;
   assign rsp_quoted       = out_res.quoted;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff <= 1'b0;
         pending_ff   <= '0;
      end else if (accept) begin
         in_string_ff <= in_string_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

[rtl/qst_checker.sv]
// ----------------------------------------------------------------------------
// qst_checker
// port-level checks on the tokenizer, bound to the top level
// ----------------------------------------------------------------------------
`include "quoted_string_tokenizer_core_assert.svh"

module qst_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_kind,
   input logic [7:0]                    rsp_char_out,
   input logic [qst_pkg::OUT_LEN_W-1:0] rsp_token_length,
   input logic                          rsp_quoted,
   input logic                          rsp_last
);
   import qst_pkg::*;

   // stalled word keeps its kind, character and last flag
   `QST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_char_out) && $stable(rsp_last))
   // more words of the same byte follow at once
   `QST_ASSERT_NEXT(a_burst_cont, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid)
   // end-of-token words carry no character
   `QST_ASSERT_NOW(a_end_no_char, clock, reset, rsp_valid && (rsp_kind == KIND_END), rsp_char_out == 8'd0)
   // punctuation is never quoted and has no length
   `QST_ASSERT_NOW(a_punct_plain, clock, reset, rsp_valid && (rsp_kind == KIND_PUNCT), !rsp_quoted && (rsp_token_length == '0))
   // with nothing to hand out the input side is open
   `QST_ASSERT_NOW(a_idle_ready, clock, reset, !rsp_valid, req_ready)

endmodule

bind quoted_string_tokenizer_core qst_checker u_qst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_char_out     (rsp_char_out),
   .rsp_token_length (rsp_token_length),
   .rsp_quoted       (rsp_quoted),
   .rsp_last         (rsp_last)
);
